// File: rtl/axis_angle_rotation_matrix_macros.svh
// ----------------------------------------------------------------------------
// axis angle rotation matrix assertion macros
// shared concurrent assertion forms used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH

// same-cycle implication
`define AARM_ASSERT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define AARM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/aarm_pkg.sv
// ----------------------------------------------------------------------------
// aarm_pkg
// types, widths and the arctangent table of the axis angle rotation matrix
// ----------------------------------------------------------------------------
package aarm_pkg;

   localparam int ANGLE_BITS    = 16;
   localparam int COEF_BITS     = 16;
   localparam int CORDIC_STAGES = 16;

   localparam int PHASE_W = 16;
   localparam int AXIS_W  = 16;
   localparam int ENTRY_W = 16;

   // cordic x/y carry COEF_BITS fraction bits plus headroom for gain growth
   localparam int XY_W = COEF_BITS + 3;
   // turn accumulator, 2^32 is a full turn, one guard bit
   localparam int Z_W  = 33;

   localparam logic [31:0] GAIN_K32 = 32'h9B74EDA8;

   typedef struct packed {
      logic        [PHASE_W-1:0] angle_phase;
      logic signed [AXIS_W-1:0]  axis_x;
      logic signed [AXIS_W-1:0]  axis_y;
      logic signed [AXIS_W-1:0]  axis_z;
   } req_type;

   typedef struct packed {
      logic signed [ENTRY_W-1:0] m00;
      logic signed [ENTRY_W-1:0] m01;
      logic signed [ENTRY_W-1:0] m02;
      logic signed [ENTRY_W-1:0] m10;
      logic signed [ENTRY_W-1:0] m11;
      logic signed [ENTRY_W-1:0] m12;
      logic signed [ENTRY_W-1:0] m20;
      logic signed [ENTRY_W-1:0] m21;
      logic signed [ENTRY_W-1:0] m22;
   } rsp_type;

   typedef struct packed {
      logic signed [AXIS_W-1:0] axis_x;
      logic signed [AXIS_W-1:0] axis_y;
      logic signed [AXIS_W-1:0] axis_z;
   } axis_type;

   // sine and cosine in Q2.(COEF_BITS-2) with the axis riding along
   typedef struct packed {
      axis_type                   axis;
      logic signed [COEF_BITS-1:0] sine;
      logic signed [COEF_BITS-1:0] cosine;
   } trig_type;

   // round(atan(2^-i) / (2 pi) * 2^32)
   function automatic logic [31:0] atan_turn(input int idx);
      logic [31:0] val;
      case (idx)
         0:       val = 32'h20000000;
         1:       val = 32'h12E4051E;
         2:       val = 32'h09FB385B;
         3:       val = 32'h051111D4;
         4:       val = 32'h028B0D43;
         5:       val = 32'h0145D7E1;
         6:       val = 32'h00A2F61E;
         7:       val = 32'h00517C55;
         8:       val = 32'h0028BE53;
         9:       val = 32'h00145F2F;
         10:      val = 32'h000A2F98;
         11:      val = 32'h000517CC;
         12:      val = 32'h00028BE6;
         13:      val = 32'h000145F3;
         14:      val = 32'h0000A2FA;
         15:      val = 32'h0000517D;
         16:      val = 32'h000028BE;
         17:      val = 32'h0000145F;
         18:      val = 32'h00000A30;
         19:      val = 32'h00000518;
         20:      val = 32'h0000028C;
         21:      val = 32'h00000146;
         22:      val = 32'h000000A3;
         23:      val = 32'h00000051;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

endpackage

// File: rtl/axis_angle_rotation_matrix.sv
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix
// 3x3 rotation matrix from an angle and an axis, fully pipelined
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one transaction: angle_phase (fraction of a full turn) and
//   an axis in signed Q2.14. rsp_* returns the nine entries m00..m22 in
//   signed Q2.14, saturated; the axis is used as given, not normalized.
//   both channels are valid/ready; a transaction moves when both are high.
//   pipeline: the one-stage-per-iteration cordic (18 stages) and the
//   five-stage product pipeline behind it.
//   throughput: one transaction per cycle when the receiver does not stall.
//   stall: every stage holds its own valid bit and empty stages fill while
//   rsp_ready is low, so req_ready stays high until the pipeline is full;
//   nothing is dropped or repeated.
//   reset: synchronous, clears all valid bits; no transaction is in flight
//   afterwards and req_ready is high in the next cycle.
// ----------------------------------------------------------------------------
`include "axis_angle_rotation_matrix_macros.svh"

module axis_angle_rotation_matrix
   import aarm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic     trig_valid;
   logic     trig_ready;
   trig_type trig_data;

   aarm_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (trig_valid),
      .out_ready (trig_ready),
      .out_data  (trig_data)
   );

   aarm_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (trig_valid),
      .in_ready  (trig_ready),
      .in_data   (trig_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   // an open output slot propagates ready all the way back to the input
   `AARM_ASSERT(a_ready_chain, clock, reset, (!rsp_valid || rsp_ready), req_ready, "input stalled with open output slot")
   // sine/cosine hand-off between the two pipelines holds while blocked
   `AARM_ASSERT_NEXT(a_trig_hold, clock, reset, (trig_valid && !trig_ready), (trig_valid && $stable(trig_data)), "trig transaction lost while stalled")
   // reset empties the whole pipeline
   `AARM_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, (!rsp_valid && !trig_valid), "pipeline not empty after reset")

endmodule

// File: rtl/aarm_cordic.sv
// ----------------------------------------------------------------------------
// aarm_cordic
// pipelined rotation-mode cordic, one stage per iteration, gives sine/cosine
// ----------------------------------------------------------------------------
module aarm_cordic
   import aarm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  req_type  in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output trig_type out_data
);

   // prologue, one stage per iteration, rounding stage
   localparam int NS   = CORDIC_STAGES + 2;
   localparam int LAST = NS - 1;
   localparam int KS   = 32 - COEF_BITS;

   localparam logic [63:0] X_INIT64 = (64'(GAIN_K32) + ((64'd1 << KS) >> 1)) >> KS;
   localparam logic signed [XY_W-1:0] X_INIT = XY_W'(X_INIT64);

   localparam logic [PHASE_W-1:0] ANGLE_MASK  = PHASE_W'((64'd1 << ANGLE_BITS) - 1);
   localparam int                 ANGLE_SHIFT = 32 - ANGLE_BITS;

   localparam logic signed [XY_W:0] LIM_HI = (XY_W+1)'((64'd1 << (COEF_BITS-1)) - 1);
   localparam logic signed [XY_W:0] LIM_LO = ~LIM_HI;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_prev;
   logic [NS:0]   ready;

   logic signed [XY_W-1:0] x_ff    [CORDIC_STAGES+1];
   logic signed [XY_W-1:0] y_ff    [CORDIC_STAGES+1];
   logic signed [Z_W-1:0]  z_ff    [CORDIC_STAGES+1];
   logic                   flip_ff [CORDIC_STAGES+1];
   axis_type               axis_ff [CORDIC_STAGES+1];
   trig_type               trig_ff;

   logic [31:0]           z32;
   logic [31:0]           z32_red;
   logic                  flip;
   logic signed [Z_W-1:0] z_init;

   function automatic logic signed [COEF_BITS-1:0] trig_round(
      input logic signed [XY_W-1:0] v,
      input logic                   neg
   );
      logic signed [XY_W:0] w;
      logic signed [XY_W:0] r;
      logic signed [COEF_BITS-1:0] res;
      w = {v[XY_W-1], v};
      if (neg) begin
         w = -w;
      end
      r = (w + (XY_W+1)'(2)) >>> 2;
      if (r > LIM_HI) begin
         res = LIM_HI[COEF_BITS-1:0];
      end else if (r < LIM_LO) begin
         res = LIM_LO[COEF_BITS-1:0];
      end else begin
         res = r[COEF_BITS-1:0];
      end
      return res;
   endfunction

   // a stage takes new data when it is empty or its successor moves
   assign ready[NS] = out_ready;
   for (genvar k = 0; k < NS; k++) begin : g_ready
      assign ready[k] = !valid_ff[k] || ready[k+1];
   end

   assign valid_prev = {valid_ff[NS-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= (valid_ff & ~ready[NS-1:0]) | (valid_prev & ready[NS-1:0]);
      end
   end

   // quadrants 1 and 2 are turned by half a turn, results negated later
   always_comb begin
      z32     = 32'(in_data.angle_phase & ANGLE_MASK) << ANGLE_SHIFT;
      flip    = z32[31] ^ z32[30];
      z32_red = {z32[31] ^ flip, z32[30:0]};
      z_init  = {{(Z_W-32){z32_red[31]}}, z32_red};
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         x_ff[0]    <= X_INIT;
         y_ff[0]    <= '0;
         z_ff[0]    <= z_init;
         flip_ff[0] <= flip;
         axis_ff[0] <= {in_data.axis_x, in_data.axis_y, in_data.axis_z};
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
      logic signed [XY_W-1:0] dx;
      logic signed [XY_W-1:0] dy;
      logic signed [Z_W-1:0]  step;

      assign dx   = y_ff[i] >>> i;
      assign dy   = x_ff[i] >>> i;
      assign step = Z_W'(atan_turn(i));

      // zero residual turns the positive way
      always_ff @(posedge clock) begin
         if (ready[i+1]) begin
            if (!z_ff[i][Z_W-1]) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - step;
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + step;
            end
            flip_ff[i+1] <= flip_ff[i];
            axis_ff[i+1] <= axis_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[LAST]) begin
         trig_ff.axis   <= axis_ff[CORDIC_STAGES];
         trig_ff.cosine <= trig_round(x_ff[CORDIC_STAGES], flip_ff[CORDIC_STAGES]);
         trig_ff.sine   <= trig_round(y_ff[CORDIC_STAGES], flip_ff[CORDIC_STAGES]);
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[LAST];
   assign out_data  = trig_ff;

endmodule

// File: rtl/aarm_matrix.sv
// ----------------------------------------------------------------------------
// aarm_matrix
// five-stage product pipeline forming the nine rotation entries
// ----------------------------------------------------------------------------
module aarm_matrix
   import aarm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  trig_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output rsp_type  out_data
);

   localparam int NS    = 5;
   localparam int P_W   = 2 * AXIS_W;
   localparam int S_W   = P_W + 1;
   localparam int OMC_W = COEF_BITS + 1;
   localparam int AS_W  = AXIS_W + COEF_BITS;
   localparam int D_W   = S_W + COEF_BITS;
   localparam int O_W   = P_W + OMC_W;
   localparam int V_W   = O_W + 2;

   localparam int SQ_SHIFT  = COEF_BITS - 2;
   localparam int SIN_SHIFT = 14;
   localparam int FIN_SHIFT = 14 + COEF_BITS - 2;

   localparam logic signed [OMC_W-1:0] ONE = OMC_W'(64'd1 << (COEF_BITS-2));
   localparam logic signed [V_W:0]     RND = (V_W+1)'(64'd1 << (FIN_SHIFT-1));
   localparam logic signed [V_W:0]     ENT_MAX = (V_W+1)'((64'd1 << (ENTRY_W-1)) - 1);
   localparam logic signed [V_W:0]     ENT_MIN = ~ENT_MAX;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_prev;
   logic [NS:0]   ready;

   // stage 1: axis products, one minus cosine
   logic signed [P_W-1:0]       s1_aa_ff, s1_bb_ff, s1_cc_ff, s1_ab_ff, s1_ac_ff, s1_bc_ff;
   logic signed [OMC_W-1:0]     s1_omc_ff;
   logic signed [COEF_BITS-1:0] s1_cos_ff, s1_sin_ff;
   axis_type                    s1_axis_ff;

   // stage 2: square sums, axis times sine
   logic signed [P_W-1:0]       s2_aa_ff, s2_bb_ff, s2_cc_ff, s2_ab_ff, s2_ac_ff, s2_bc_ff;
   logic signed [S_W-1:0]       s2_sx_ff, s2_sy_ff, s2_sz_ff;
   logic signed [AS_W-1:0]      s2_as_ff, s2_bs_ff, s2_cs_ff;
   logic signed [OMC_W-1:0]     s2_omc_ff;
   logic signed [COEF_BITS-1:0] s2_cos_ff;

   // stage 3: cosine and one-minus-cosine products
   logic signed [P_W-1:0]  s3_aa_ff, s3_bb_ff, s3_cc_ff;
   logic signed [D_W-1:0]  s3_dx_ff, s3_dy_ff, s3_dz_ff;
   logic signed [O_W-1:0]  s3_abo_ff, s3_aco_ff, s3_bco_ff;
   logic signed [AS_W-1:0] s3_as_ff, s3_bs_ff, s3_cs_ff;

   // stage 4: full-precision entries
   logic signed [V_W-1:0] s4_v_ff [9];
   logic signed [V_W-1:0] s4_v_in [9];

   // stage 5: rounded and saturated result
   rsp_type rsp_ff;

   logic signed [V_W-1:0] sq_a, sq_b, sq_c, sin_a, sin_b, sin_c;
   logic signed [V_W-1:0] abo, aco, bco;

   function automatic logic signed [ENTRY_W-1:0] entry_round(
      input logic signed [V_W-1:0] v
   );
      logic signed [V_W:0] r;
      logic signed [ENTRY_W-1:0] res;
      r = ((V_W+1)'(v) + RND) >>> FIN_SHIFT;
      if (r > ENT_MAX) begin
         res = ENT_MAX[ENTRY_W-1:0];
      end else if (r < ENT_MIN) begin
         res = ENT_MIN[ENTRY_W-1:0];
      end else begin
         res = r[ENTRY_W-1:0];
      end
      return res;
   endfunction

   assign ready[NS] = out_ready;
   for (genvar k = 0; k < NS; k++) begin : g_ready
      assign ready[k] = !valid_ff[k] || ready[k+1];
   end

   assign valid_prev = {valid_ff[NS-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= (valid_ff & ~ready[NS-1:0]) | (valid_prev & ready[NS-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         s1_aa_ff   <= in_data.axis.axis_x * in_data.axis.axis_x;
         s1_bb_ff   <= in_data.axis.axis_y * in_data.axis.axis_y;
         s1_cc_ff   <= in_data.axis.axis_z * in_data.axis.axis_z;
         s1_ab_ff   <= in_data.axis.axis_x * in_data.axis.axis_y;
         s1_ac_ff   <= in_data.axis.axis_x * in_data.axis.axis_z;
         s1_bc_ff   <= in_data.axis.axis_y * in_data.axis.axis_z;
         s1_omc_ff  <= ONE - OMC_W'(in_data.cosine);
         s1_cos_ff  <= in_data.cosine;
         s1_sin_ff  <= in_data.sine;
         s1_axis_ff <= in_data.axis;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[1]) begin
         s2_aa_ff  <= s1_aa_ff;
         s2_bb_ff  <= s1_bb_ff;
         s2_cc_ff  <= s1_cc_ff;
         s2_ab_ff  <= s1_ab_ff;
         s2_ac_ff  <= s1_ac_ff;
         s2_bc_ff  <= s1_bc_ff;
         s2_sx_ff  <= S_W'(s1_bb_ff) + S_W'(s1_cc_ff);
         s2_sy_ff  <= S_W'(s1_aa_ff) + S_W'(s1_cc_ff);
         s2_sz_ff  <= S_W'(s1_aa_ff) + S_W'(s1_bb_ff);
         s2_as_ff  <= s1_axis_ff.axis_x * s1_sin_ff;
         s2_bs_ff  <= s1_axis_ff.axis_y * s1_sin_ff;
         s2_cs_ff  <= s1_axis_ff.axis_z * s1_sin_ff;
         s2_omc_ff <= s1_omc_ff;
         s2_cos_ff <= s1_cos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[2]) begin
         s3_aa_ff  <= s2_aa_ff;
         s3_bb_ff  <= s2_bb_ff;
         s3_cc_ff  <= s2_cc_ff;
         s3_dx_ff  <= s2_sx_ff * s2_cos_ff;
         s3_dy_ff  <= s2_sy_ff * s2_cos_ff;
         s3_dz_ff  <= s2_sz_ff * s2_cos_ff;
         s3_abo_ff <= s2_ab_ff * s2_omc_ff;
         s3_aco_ff <= s2_ac_ff * s2_omc_ff;
         s3_bco_ff <= s2_bc_ff * s2_omc_ff;
         s3_as_ff  <= s2_as_ff;
         s3_bs_ff  <= s2_bs_ff;
         s3_cs_ff  <= s2_cs_ff;
      end
   end

   // squares scaled by one, sine terms scaled by 2^14, all in one fraction format
   always_comb begin
      sq_a  = V_W'(s3_aa_ff) <<< SQ_SHIFT;
      sq_b  = V_W'(s3_bb_ff) <<< SQ_SHIFT;
      sq_c  = V_W'(s3_cc_ff) <<< SQ_SHIFT;
      sin_a = V_W'(s3_as_ff) <<< SIN_SHIFT;
      sin_b = V_W'(s3_bs_ff) <<< SIN_SHIFT;
      sin_c = V_W'(s3_cs_ff) <<< SIN_SHIFT;
      abo   = V_W'(s3_abo_ff);
      aco   = V_W'(s3_aco_ff);
      bco   = V_W'(s3_bco_ff);
      s4_v_in[0] = sq_a + V_W'(s3_dx_ff);
      s4_v_in[1] = abo + sin_c;
      s4_v_in[2] = aco - sin_b;
      s4_v_in[3] = abo - sin_c;
      s4_v_in[4] = sq_b + V_W'(s3_dy_ff);
      s4_v_in[5] = bco + sin_a;
      s4_v_in[6] = aco + sin_b;
      s4_v_in[7] = bco - sin_a;
      s4_v_in[8] = sq_c + V_W'(s3_dz_ff);
   end

   always_ff @(posedge clock) begin
      if (ready[3]) begin
         s4_v_ff <= s4_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[4]) begin
         rsp_ff <= '{m00: entry_round(s4_v_ff[0]),
                     m01: entry_round(s4_v_ff[1]),
                     m02: entry_round(s4_v_ff[2]),
                     m10: entry_round(s4_v_ff[3]),
                     m11: entry_round(s4_v_ff[4]),
                     m12: entry_round(s4_v_ff[5]),
                     m20: entry_round(s4_v_ff[6]),
                     m21: entry_round(s4_v_ff[7]),
                     m22: entry_round(s4_v_ff[8])};
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[NS-1];
   assign out_data  = rsp_ff;

endmodule
